FILE: design/rsfl_pkg.sv
package rsfl_pkg;

    localparam int unsigned CmdW    = 2;
    localparam int unsigned PosW    = 10;
    localparam int unsigned WordW   = 32;
    localparam int unsigned StatusW = 2;

    localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
    localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CmdW-1:0] CMD_READ   = 2'd2;

    localparam logic [StatusW-1:0] STATUS_OK     = 2'd0;
    localparam logic [StatusW-1:0] STATUS_FULL   = 2'd1;
    localparam logic [StatusW-1:0] STATUS_BADPOS = 2'd2;

    localparam logic [WordW-1:0] LINK_END = '1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl;

endpackage

FILE: design/record_store_free_list_unit.sv
// record store with free-list slot allocation
// command channel: a beat is taken on a rising edge with start high and busy low;
//   i_cmd selects insert, remove or read, i_position names the slot for remove
//   and read, i_record_code and i_salary_cents are the words stored by insert
// result channel: o_valid is high for one cycle per command with o_slot,
//   o_code_out, o_salary_out and o_status; the receiver cannot hold it off
// the result and o_valid are registered at the end of the execute state that follows the accepting edge
// no new command is taken while busy; the load step reads the record
//   memories (the free-list link of the head slot, or the addressed slot), the
//   execute step updates the list head and top mark and writes the memories
// busy is high in the cycle after a command is taken
// reset empties the free list and clears the top mark; record memories are
//   not cleared, and no slot below the top mark can be read before it is written
module record_store_free_list_unit
    import rsfl_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [CmdW-1:0]         i_cmd,
    input  logic [PosW-1:0]         i_position,
    input  logic signed [WordW-1:0] i_record_code,
    input  logic [WordW-1:0]        i_salary_cents,
    output logic                    o_valid,
    output logic [PosW-1:0]         o_slot,
    output logic signed [WordW-1:0] o_code_out,
    output logic [WordW-1:0]        o_salary_out,
    output logic [StatusW-1:0]      o_status
);

    t_ctl ctl;

    rsfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    rsfl_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cmd          (i_cmd),
        .i_position     (i_position),
        .i_record_code  (i_record_code),
        .i_salary_cents (i_salary_cents),
        .o_valid        (o_valid),
        .o_slot         (o_slot),
        .o_code_out     (o_code_out),
        .o_salary_out   (o_salary_out),
        .o_status       (o_status)
    );

endmodule

FILE: design/rsfl_ctrl.sv
module rsfl_ctrl
    import rsfl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl.load = 1'b0;
        o_ctl.exec = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state == ST_EXEC);

endmodule

FILE: design/rsfl_dp.sv
module rsfl_dp
    import rsfl_pkg::*;
#(
    parameter int unsigned CAPACITY = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    input  logic [CmdW-1:0]           i_cmd,
    input  logic [PosW-1:0]           i_position,
    input  logic signed [WordW-1:0]   i_record_code,
    input  logic [WordW-1:0]          i_salary_cents,
    output logic                      o_valid,
    output logic [PosW-1:0]           o_slot,
    output logic signed [WordW-1:0]   o_code_out,
    output logic [WordW-1:0]          o_salary_out,
    output logic [StatusW-1:0]        o_status
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned TW = $clog2(CAPACITY + 1);
    localparam int unsigned CW = (TW > PosW) ? TW : PosW;
    localparam logic [TW-1:0] TOP_MAX = TW'(CAPACITY);

    logic [WordW-1:0] code_mem [CAPACITY];
    logic [WordW-1:0] sal_mem  [CAPACITY];

    logic [AW-1:0]      r_head;
    logic               r_head_vld;
    logic [TW-1:0]      r_top;
    logic [CmdW-1:0]    r_cmd;
    logic [AW-1:0]      r_idx;
    logic               r_bad;
    logic [PosW-1:0]    r_pos;
    logic [WordW-1:0]   r_code;
    logic [WordW-1:0]   r_sal;
    logic [WordW-1:0]   r_rd_code;
    logic [WordW-1:0]   r_rd_sal;

    logic               r_valid;
    logic [PosW-1:0]    r_slot;
    logic [WordW-1:0]   r_code_out;
    logic [WordW-1:0]   r_sal_out;
    logic [StatusW-1:0] r_status;

    logic [CW-1:0]      pos_ext;
    logic [AW-1:0]      rd_addr;

    logic [AW-1:0]      n_head;
    logic               n_head_vld;
    logic [TW-1:0]      n_top;
    logic               wr_code;
    logic               wr_sal;
    logic [AW-1:0]      wr_addr;
    logic [WordW-1:0]   wr_data;
    logic [CW-1:0]      slot_ext;
    logic [PosW-1:0]    n_slot;
    logic [WordW-1:0]   n_code_out;
    logic [WordW-1:0]   n_sal_out;
    logic [StatusW-1:0] n_status;

    // input capture and memory lookup
    assign pos_ext = CW'(i_position);
    assign rd_addr = (i_cmd == CMD_INSERT) ? r_head : pos_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_cmd;
            r_pos     <= i_position;
            r_idx     <= pos_ext[AW-1:0];
            r_bad     <= (pos_ext >= CW'(r_top));
            r_code    <= i_record_code;
            r_sal     <= i_salary_cents;
            r_rd_code <= code_mem[rd_addr];
            r_rd_sal  <= sal_mem[rd_addr];
        end
    end

    // execute
    always_comb begin
        n_head     = r_head;
        n_head_vld = r_head_vld;
        n_top      = r_top;
        wr_code    = 1'b0;
        wr_sal     = 1'b0;
        wr_addr    = r_idx;
        wr_data    = r_code;
        slot_ext   = CW'(r_pos);
        n_code_out = '0;
        n_sal_out  = '0;
        n_status   = STATUS_OK;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (r_head_vld) begin
                    wr_addr  = r_head;
                    wr_code  = 1'b1;
                    wr_sal   = 1'b1;
                    slot_ext = CW'(r_head);
                    n_head   = r_rd_code[AW-1:0];
                    n_head_vld = (r_rd_code != LINK_END) && (r_rd_code < 32'(r_top));
                end else if (r_top < TOP_MAX) begin
                    wr_addr  = r_top[AW-1:0];
                    wr_code  = 1'b1;
                    wr_sal   = 1'b1;
                    slot_ext = CW'(r_top);
                    n_top    = r_top + 1'b1;
                end else begin
                    slot_ext = '0;
                    n_status = STATUS_FULL;
                end
            end
            CMD_REMOVE: begin
                if (r_bad) begin
                    n_status = STATUS_BADPOS;
                end else begin
                    wr_code    = 1'b1;
                    wr_data    = r_head_vld ? 32'(r_head) : LINK_END;
                    n_head     = r_idx;
                    n_head_vld = 1'b1;
                end
            end
            CMD_READ: begin
                if (r_bad) begin
                    n_status = STATUS_BADPOS;
                end else begin
                    n_code_out = r_rd_code;
                    n_sal_out  = r_rd_sal;
                end
            end
            default: begin
                slot_ext = '0;
            end
        endcase
        n_slot = slot_ext[PosW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && wr_code) begin
            code_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.exec && wr_sal) begin
            sal_mem[wr_addr] <= r_sal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= 1'b0;
            r_top      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_ctl.exec;
            if (i_ctl.exec) begin
                r_head_vld <= n_head_vld;
                r_top      <= n_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_head     <= n_head;
            r_slot     <= n_slot;
            r_code_out <= n_code_out;
            r_sal_out  <= n_sal_out;
            r_status   <= n_status;
        end
    end

    assign o_valid      = r_valid;
    assign o_slot       = r_slot;
    assign o_code_out   = r_code_out;
    assign o_salary_out = r_sal_out;
    assign o_status     = r_status;

endmodule
